// File: rtl/tcw_pkg.sv
// Shared constants, types and helpers for the text console writer.
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int TAB_STOP    = 4;
  localparam int SCREEN_SIZE = COLUMNS * ROWS;

  // Field widths
  localparam int ACTION_W  = 2;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int CELL_W    = CHAR_W + ATTR_W;
  localparam int POS_W     = 11;
  localparam int ADDR_W    = 11;
  localparam int COLOR_W   = 4;
  localparam int REG_IDX_W = 1;

  // Derived widths
  localparam int WALK_W      = $clog2(SCREEN_SIZE);
  localparam int COL_W       = $clog2(COLUMNS);
  localparam int TPH_W       = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int COL_WRAP_PH = COLUMNS % TAB_STOP;
  localparam int SIZE_PH     = SCREEN_SIZE % TAB_STOP;

  // Queue depth between front and back, and ahead of the result ports
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Character codes
  localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'h20;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_FG = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_BG = 1'b1;
  localparam logic [COLOR_W-1:0]   FG_RESET = 4'd0;
  localparam logic [COLOR_W-1:0]   BG_RESET = 4'd7;

  // Command kinds decided by the front
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] K_CHAR    = 3'd0;
  localparam logic [KIND_W-1:0] K_NEWLINE = 3'd1;
  localparam logic [KIND_W-1:0] K_TAB     = 3'd2;
  localparam logic [KIND_W-1:0] K_CLEAR   = 3'd3;
  localparam logic [KIND_W-1:0] K_READ    = 3'd4;
  localparam logic [KIND_W-1:0] K_NOP     = 3'd5;

  typedef logic [TPH_W+1:0] tph_wide_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CELL_W-1:0] cell_word;  // attribute in the high byte
    logic [ADDR_W-1:0] addr;
    logic              addr_ok;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]  text_position;
    logic [POS_W-1:0]  cursor_shown;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic              scrolled;
  } result_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

  // Reduce a small sum below 3*TAB_STOP modulo TAB_STOP
  function automatic logic [TPH_W-1:0] tph_reduce(input tph_wide_t v);
    tph_wide_t r;
    r = v;
    if (r >= (TPH_W+2)'(2 * TAB_STOP)) r = r - (TPH_W+2)'(2 * TAB_STOP);
    if (r >= (TPH_W+2)'(TAB_STOP)) r = r - (TPH_W+2)'(TAB_STOP);
    return r[TPH_W-1:0];
  endfunction

endpackage

// File: rtl/tcw_front.sv
// Front: accepts items, holds the color registers and classifies each item.
module tcw_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [tcw_pkg::ACTION_W-1:0]   action,
  input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
  input  logic [tcw_pkg::ADDR_W-1:0]     read_address,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]    cfg_data,
  input  logic                           cmd_full,
  input  tcw_pkg::back_status_t          back_status,
  output logic                           cmd_push,
  output tcw_pkg::cmd_t                  cmd
);
  import tcw_pkg::*;

  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;
  logic [ATTR_W-1:0]  attr;

  // Color registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= FG_RESET;
      bg_color <= BG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FG:  fg_color <= cfg_data;
        REG_BG:  bg_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // No items while the screen store is being cleared after reset
  assign full     = cmd_full | back_status.init_busy;
  assign cmd_push = push & ~full;
  assign attr     = {fg_color, bg_color};

  // Classify
  always_comb begin
    cmd.addr      = read_address;
    cmd.addr_ok   = (read_address < ADDR_W'(SCREEN_SIZE));
    cmd.cell_word = {attr, char_code};
    unique case (action)
      ACT_PUT: begin
        if (char_code == CODE_NEWLINE) cmd.kind = K_NEWLINE;
        else if (char_code == CODE_TAB) cmd.kind = K_TAB;
        else cmd.kind = K_CHAR;
      end
      ACT_CLEAR: begin
        cmd.kind      = K_CLEAR;
        cmd.cell_word = {attr, CODE_SPACE};
      end
      ACT_READ: cmd.kind = K_READ;
      default:  cmd.kind = K_NOP;
    endcase
  end

endmodule

// File: rtl/tcw_cmd_queue.sv
// Short command queue between the front and the back.
module tcw_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  tcw_pkg::cmd_t wr_item,
  output logic          full,
  input  logic          rd,
  output logic          empty,
  output tcw_pkg::cmd_t head
);
  import tcw_pkg::*;

  cmd_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_wr;
  logic               do_rd;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr & ~full;
  assign do_rd = rd & ~empty;
  assign head  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_item;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (!do_wr && do_rd) count <= count - 1'b1;
    end
  end

endmodule

// File: rtl/tcw_back.sv
// Back: screen store, scroll/clear walks, position tracking and results.
module tcw_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_empty,
  input  tcw_pkg::cmd_t         cmd,
  output logic                  cmd_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output tcw_pkg::result_t      res,
  output tcw_pkg::back_status_t back_status
);
  import tcw_pkg::*;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_SETTLE = 3'd1;
  localparam logic [2:0] S_IDLE   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_PUT    = 3'd4;
  localparam logic [2:0] S_CLEAR  = 3'd5;
  localparam logic [2:0] S_READ   = 3'd6;

  localparam logic [POS_W-1:0]  SIZE_POS  = POS_W'(SCREEN_SIZE);
  localparam logic [POS_W:0]    SIZE_WIDE = (POS_W+1)'(SCREEN_SIZE);
  localparam logic [POS_W-1:0]  COLS_POS  = POS_W'(COLUMNS);
  localparam logic [WALK_W-1:0] COLS_WALK = WALK_W'(COLUMNS);
  localparam logic [WALK_W-1:0] LAST_WALK = WALK_W'(SCREEN_SIZE - 1);
  localparam logic [WALK_W-1:0] COPY_END  = WALK_W'(SCREEN_SIZE - COLUMNS);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
  localparam logic [COL_W:0]    COLS_WIDE = (COL_W+1)'(COLUMNS);
  localparam logic [TPH_W:0]    TAB_K     = (TPH_W+1)'(TAB_STOP);
  localparam logic [TPH_W-1:0]  TPH_LAST  = TPH_W'(TAB_STOP - 1);
  localparam logic [TPH_W-1:0]  TPH_SIZE  = TPH_W'(SIZE_PH);
  localparam tph_wide_t         TAB_V     = (TPH_W+2)'(TAB_STOP);
  localparam tph_wide_t         CWP_V     = (TPH_W+2)'(COL_WRAP_PH);

  logic [2:0]         state;
  logic [WALK_W-1:0]  walk;
  cmd_t               cur;
  logic               cur_scrolled;

  // Position state: pos, its column, pos mod tab stop, column mod tab stop
  logic [POS_W-1:0]   pos;
  logic [COL_W-1:0]   col;
  logic [TPH_W-1:0]   tph;
  logic [TPH_W-1:0]   ctph;
  logic [POS_W-1:0]   cursor;

  logic [POS_W-1:0]   pos_next;
  logic [COL_W-1:0]   col_next;
  logic [TPH_W-1:0]   tph_next;
  logic [TPH_W-1:0]   ctph_next;
  logic [POS_W-1:0]   cursor_next;
  logic [TPH_W-1:0]   tph_scroll;

  logic [COL_W:0]     nl_step;
  logic [TPH_W:0]     tab_step;
  logic [POS_W:0]     tab_pos;
  logic [COL_W:0]     tab_col;

  // Screen store and its ports
  logic [CELL_W-1:0]  screen [SCREEN_SIZE];
  logic [CELL_W-1:0]  rd_data;
  logic [WALK_W-1:0]  rd_addr;
  logic               wr_en;
  logic               wr_copy;
  logic [WALK_W-1:0]  wr_addr;
  logic [CELL_W-1:0]  wr_data;

  logic               start_ok;

  assign back_status.init_busy = (state == S_INIT) || (state == S_SETTLE);

  // A read waits for a pending cell write to land
  assign start_ok = !cmd_empty && !res_full && !((cmd.kind == K_READ) && wr_en);

  // The write stage is registered behind the read, so copies take the read data
  always_ff @(posedge clk) begin
    if (wr_en) screen[wr_addr] <= wr_copy ? rd_data : wr_data;
    rd_data <= screen[rd_addr];
  end

  assign tph_scroll = tph_reduce(tph_wide_t'(tph) + TAB_V - CWP_V);

  // Position update for a put item
  always_comb begin
    nl_step     = COLS_WIDE - {1'b0, col};
    tab_step    = TAB_K - {1'b0, tph};
    tab_pos     = {1'b0, pos} + (POS_W+1)'(tab_step);
    tab_col     = {1'b0, col} + (COL_W+1)'(tab_step);
    pos_next    = pos;
    col_next    = col;
    tph_next    = tph;
    ctph_next   = ctph;
    cursor_next = cursor;
    unique case (cur.kind)
      K_CHAR: begin
        pos_next    = pos + 1'b1;
        cursor_next = pos;
        tph_next    = (tph == TPH_LAST) ? '0 : tph + 1'b1;
        if (col == COL_LAST) begin
          col_next  = '0;
          ctph_next = '0;
        end else begin
          col_next  = col + 1'b1;
          ctph_next = (ctph == TPH_LAST) ? '0 : ctph + 1'b1;
        end
      end
      K_NEWLINE: begin
        pos_next    = pos + POS_W'(nl_step);
        cursor_next = pos_next;
        col_next    = '0;
        ctph_next   = '0;
        tph_next    = tph_reduce(tph_wide_t'(tph) + CWP_V + TAB_V - tph_wide_t'(ctph));
      end
      K_TAB: begin
        if (tab_pos > SIZE_WIDE) begin
          // saturate at the screen size, which is a row start
          pos_next  = SIZE_POS;
          col_next  = '0;
          ctph_next = '0;
          tph_next  = TPH_SIZE;
        end else begin
          pos_next = tab_pos[POS_W-1:0];
          tph_next = '0;
          if (tab_col >= COLS_WIDE) begin
            col_next  = COL_W'(tab_col - COLS_WIDE);
            ctph_next = tph_reduce(tph_wide_t'(ctph) + tph_wide_t'(tab_step) + TAB_V - CWP_V);
          end else begin
            col_next  = tab_col[COL_W-1:0];
            ctph_next = tph_reduce(tph_wide_t'(ctph) + tph_wide_t'(tab_step));
          end
        end
        cursor_next = pos_next;
      end
      default: ;
    endcase
  end

  // Queue handshakes, read address and result
  always_comb begin
    cmd_pop                = 1'b0;
    res_push               = 1'b0;
    rd_addr                = walk + COLS_WALK;
    res.text_position      = pos;
    res.cursor_shown       = cursor;
    res.cell_char          = '0;
    res.cell_attr          = '0;
    res.scrolled           = cur_scrolled;
    unique case (state)
      S_IDLE: begin
        rd_addr = WALK_W'(cmd.addr);
        if (start_ok) begin
          cmd_pop = 1'b1;
          if (cmd.kind == K_NOP) begin
            res_push     = 1'b1;
            res.scrolled = 1'b0;
          end
        end
      end
      S_PUT: begin
        res_push          = 1'b1;
        res.text_position = pos_next;
        res.cursor_shown  = cursor_next;
      end
      S_CLEAR: res_push = (walk == LAST_WALK);
      S_READ: begin
        res_push = 1'b1;
        if (cur.addr_ok) begin
          res.cell_char = rd_data[CHAR_W-1:0];
          res.cell_attr = rd_data[CELL_W-1:CHAR_W];
        end
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      walk         <= '0;
      cur_scrolled <= 1'b0;
      pos          <= '0;
      col          <= '0;
      tph          <= '0;
      ctph         <= '0;
      cursor       <= '0;
      wr_en        <= 1'b0;
    end else begin
      wr_en <= 1'b0;
      unique case (state)
        // zero every cell after reset
        S_INIT: begin
          wr_en   <= 1'b1;
          wr_copy <= 1'b0;
          wr_addr <= walk;
          wr_data <= '0;
          if (walk == LAST_WALK) begin
            walk  <= '0;
            state <= S_SETTLE;
          end else begin
            walk <= walk + 1'b1;
          end
        end
        S_SETTLE: state <= S_IDLE;
        S_IDLE: begin
          if (start_ok) begin
            cur  <= cmd;
            walk <= '0;
            case (cmd.kind) inside
              K_CHAR, K_NEWLINE, K_TAB: begin
                cur_scrolled <= (pos == SIZE_POS);
                state        <= (pos == SIZE_POS) ? S_SCROLL : S_PUT;
              end
              K_CLEAR: begin
                cur_scrolled <= 1'b0;
                state        <= S_CLEAR;
              end
              K_READ: begin
                cur_scrolled <= 1'b0;
                state        <= S_READ;
              end
              default: cur_scrolled <= 1'b0;
            endcase
          end
        end
        // move each row up one, zero the last row
        S_SCROLL: begin
          wr_en   <= 1'b1;
          wr_addr <= walk;
          if (walk < COPY_END) begin
            wr_copy <= 1'b1;
          end else begin
            wr_copy <= 1'b0;
            wr_data <= '0;
          end
          if (walk == LAST_WALK) begin
            walk  <= '0;
            pos   <= pos - COLS_POS;
            tph   <= tph_scroll;
            state <= S_PUT;
          end else begin
            walk <= walk + 1'b1;
          end
        end
        S_PUT: begin
          pos    <= pos_next;
          col    <= col_next;
          tph    <= tph_next;
          ctph   <= ctph_next;
          cursor <= cursor_next;
          if (cur.kind == K_CHAR) begin
            wr_en   <= 1'b1;
            wr_copy <= 1'b0;
            wr_addr <= WALK_W'(pos);
            wr_data <= cur.cell_word;
          end
          state <= S_IDLE;
        end
        // fill with spaces in the current colors
        S_CLEAR: begin
          wr_en   <= 1'b1;
          wr_copy <= 1'b0;
          wr_addr <= walk;
          wr_data <= cur.cell_word;
          if (walk == LAST_WALK) begin
            walk  <= '0;
            state <= S_IDLE;
          end else begin
            walk <= walk + 1'b1;
          end
        end
        S_READ: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/tcw_res_queue.sv
// Result queue feeding the output ports.
module tcw_res_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  tcw_pkg::result_t wr_item,
  output logic             full,
  input  logic             rd,
  output logic             empty,
  output tcw_pkg::result_t head
);
  import tcw_pkg::*;

  result_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_wr;
  logic               do_rd;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr & ~full;
  assign do_rd = rd & ~empty;
  assign head  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_item;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (!do_wr && do_rd) count <= count - 1'b1;
    end
  end

endmodule

// File: rtl/text_console_writer.sv
// Top level of the text console writer.
//
// Items go in through a queue-style port: an item is taken when push is high
// and full is low. Results come out the same way: the oldest result sits on
// the result ports while empty is low and is taken when pop is high. Every
// item gives exactly one result. Color registers are written through
// cfg_we / cfg_index / cfg_data (0 foreground, 1 background).
//
// A plain character goes from idle to the put state, where its result is
// pushed. A read goes through the read state, and waits in idle while a
// cell write is still pending. A clear walks all 2000 cells and pushes its
// result at the last one. A put at the end of the screen first scrolls:
// 1920 row copies plus 80 cells zeroed. The 2000-cell screen store has one
// read port and one write port.
//
// Reset zeroes every cell of the store; full stays high until that pass and a settle state end.
// A stalled receiver fills the two-entry result queue, the back end then
// stops, and the two-entry command queue ahead of it raises full.
module text_console_writer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [tcw_pkg::ACTION_W-1:0]   action,
  input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
  input  logic [tcw_pkg::ADDR_W-1:0]     read_address,
  output logic                           empty,
  input  logic                           pop,
  output logic [tcw_pkg::POS_W-1:0]      text_position,
  output logic [tcw_pkg::POS_W-1:0]      cursor_shown,
  output logic [tcw_pkg::CHAR_W-1:0]     cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]     cell_attr,
  output logic                           scrolled,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]    cfg_data
);
  import tcw_pkg::*;

  logic         cmd_push;
  cmd_t         cmd_in;
  logic         cmd_full;
  logic         cmd_pop;
  logic         cmd_empty;
  cmd_t         cmd_head;
  back_status_t back_status;
  logic         res_push;
  result_t      res_in;
  logic         res_full;
  result_t      res_head;

  tcw_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .action       (action),
    .char_code    (char_code),
    .read_address (read_address),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd_full     (cmd_full),
    .back_status  (back_status),
    .cmd_push     (cmd_push),
    .cmd          (cmd_in)
  );

  tcw_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_push),
    .wr_item (cmd_in),
    .full    (cmd_full),
    .rd      (cmd_pop),
    .empty   (cmd_empty),
    .head    (cmd_head)
  );

  tcw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_empty   (cmd_empty),
    .cmd         (cmd_head),
    .cmd_pop     (cmd_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res         (res_in),
    .back_status (back_status)
  );

  tcw_res_queue u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_push),
    .wr_item (res_in),
    .full    (res_full),
    .rd      (pop),
    .empty   (empty),
    .head    (res_head)
  );

  assign text_position = res_head.text_position;
  assign cursor_shown  = res_head.cursor_shown;
  assign cell_char     = res_head.cell_char;
  assign cell_attr     = res_head.cell_attr;
  assign scrolled      = res_head.scrolled;

endmodule

// File: rtl/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
module tcw_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      full,
  input logic                      empty,
  input logic                      pop,
  input logic [tcw_pkg::POS_W-1:0]  text_position,
  input logic [tcw_pkg::POS_W-1:0]  cursor_shown,
  input logic [tcw_pkg::CHAR_W-1:0] cell_char,
  input logic [tcw_pkg::ATTR_W-1:0] cell_attr,
  input logic                      scrolled
);
  import tcw_pkg::*;

  localparam logic [POS_W-1:0] SIZE_POS  = POS_W'(SCREEN_SIZE);
  localparam logic [POS_W-1:0] LAST_ROW0 = POS_W'(SCREEN_SIZE - COLUMNS);

  // Reset leaves no result and blocks input for the clearing pass
  a_reset_state: assert property (@(posedge clk) rst |=> full && empty)
    else $error("full/empty wrong after reset");

  // A waiting result holds until taken
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(text_position) && $stable(cursor_shown)
      && $stable(cell_char) && $stable(cell_attr) && $stable(scrolled))
    else $error("result changed while stalled");

  // Positions never pass the screen size
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> text_position <= SIZE_POS && cursor_shown <= SIZE_POS)
    else $error("position out of range");

  // After a scroll the position lies on the last row or at its end
  a_scroll_pos: assert property (@(posedge clk) disable iff (rst)
    !empty && scrolled |-> text_position > LAST_ROW0 && text_position <= SIZE_POS
      && cell_char == '0 && cell_attr == '0)
    else $error("scroll result inconsistent");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
